### src/pmm_pkg.sv
`default_nettype none
package pmm_pkg;

  localparam int ADDR_BITS   = 20;
  localparam int OFFSET_BITS = 10;
  localparam int MAX_PROCS   = 16;
  localparam int FRAME_BITS  = ADDR_BITS - OFFSET_BITS;
  localparam int NUM_FRAMES  = 1 << FRAME_BITS;
  localparam int PID_BITS    = 4;
  localparam int BRK_BITS    = 21;
  localparam int SIZE_BITS   = 21;
  localparam int NPG_BITS    = SIZE_BITS - OFFSET_BITS + 1;
  localparam int CMD_BITS    = 2;
  localparam int BYTE_BITS   = 8;

  localparam logic [BRK_BITS-1:0] BRK_RESET = BRK_BITS'(1024);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [PID_BITS-1:0]   owner;
    logic [FRAME_BITS:0]   link;
    logic [FRAME_BITS-1:0] vpage;
    logic                  mapped;
  } frame_entry_t;

  typedef struct packed {
    logic                  en;
    logic [FRAME_BITS-1:0] addr;
    frame_entry_t          data;
  } frame_wr_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [BYTE_BITS-1:0] data;
  } byte_req_t;

endpackage
`default_nettype wire

### src/pmm_if.sv
`default_nettype none
interface pmm_req_if import pmm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  command;
  logic [PID_BITS-1:0]  pid;
  logic [SIZE_BITS-1:0] size;
  logic [ADDR_BITS-1:0] address;
  logic [BYTE_BITS-1:0] write_data;
  modport source (output valid, command, pid, size, address, write_data, input ready);
  modport sink (input valid, command, pid, size, address, write_data, output ready);
endinterface

interface pmm_rsp_if import pmm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [ADDR_BITS-1:0] base_address;
  logic [BYTE_BITS-1:0] read_data;
  modport source (output valid, status, base_address, read_data, input ready);
  modport sink (input valid, status, base_address, read_data, output ready);
endinterface

interface pmm_cfg_if import pmm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BRK_BITS-1:0] initial_break;
  modport source (output valid, initial_break, input ready);
  modport sink (input valid, initial_break, output ready);
endinterface
`default_nettype wire

### src/pmm_frame_mem.sv
`default_nettype none
module pmm_frame_mem import pmm_pkg::*; (
  input  logic                  clk,
  input  frame_wr_t             wr,
  input  logic [FRAME_BITS-1:0] rd_addr,
  output frame_entry_t          rd_data
);

  frame_entry_t mem [NUM_FRAMES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### src/pmm_byte_mem.sv
`default_nettype none
module pmm_byte_mem import pmm_pkg::*; (
  input  logic                 clk,
  input  byte_req_t            req,
  output logic [BYTE_BITS-1:0] rd_data
);

  logic [BYTE_BITS-1:0] mem [1 << ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.data;
    end
    rd_data <= mem[req.addr];
  end

endmodule
`default_nettype wire

### src/pmm_ctrl.sv
`default_nettype none
module pmm_ctrl import pmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pmm_req_if.sink               req,
  pmm_rsp_if.source             rsp,
  pmm_cfg_if.sink               cfg,
  output frame_wr_t             fw,
  output logic [FRAME_BITS-1:0] frame_rd_addr,
  input  frame_entry_t          frame_rd,
  output byte_req_t             br,
  input  logic [BYTE_BITS-1:0]  byte_rd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_COUNT, S_ASSIGN, S_LINK_END, S_LOOKUP,
    S_WALK_RD, S_WALK_CHK, S_BREAK, S_MEM_ISSUE, S_MEM_WAIT, S_DONE
  } state_t;

  state_t                state;
  logic [ADDR_BITS-1:0]  clr_cnt;
  cmd_t                  cmd_r;
  logic [PID_BITS-1:0]   pid_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [BYTE_BITS-1:0]  wdata_r;
  logic [NPG_BITS-1:0]   npg;
  logic [FRAME_BITS:0]   scan_idx;
  logic                  rd_pend;
  logic [FRAME_BITS-1:0] rd_idx;
  logic [FRAME_BITS:0]   free_cnt;
  logic [NPG_BITS-1:0]   k;
  logic [FRAME_BITS-1:0] prev;
  logic [FRAME_BITS-1:0] vp0;
  logic [FRAME_BITS:0]   wf;
  logic [FRAME_BITS:0]   wn;
  logic [BRK_BITS-1:0]   bp [MAX_PROCS];
  logic                  res_status;
  logic [ADDR_BITS-1:0]  res_base;
  logic [BYTE_BITS-1:0]  res_rdata;
  logic                  out_valid;
  logic                  out_status;
  logic [ADDR_BITS-1:0]  out_base;
  logic [BYTE_BITS-1:0]  out_rdata;

  logic [BRK_BITS-1:0]   bp_cur;
  logic [BRK_BITS:0]     alloc_end;
  logic                  alloc_fail;
  logic [BRK_BITS-1:0]   rel_bytes;
  logic [BRK_BITS:0]     brk_cmp;
  logic [SIZE_BITS:0]    size_round;
  logic [NPG_BITS-1:0]   k_m1;
  logic                  lookup_hit;
  logic                  walk_ok;
  logic                  scan_end;

  assign bp_cur     = bp[pid_r];
  assign alloc_end  = {1'b0, bp_cur} + {npg, {OFFSET_BITS{1'b0}}};
  assign alloc_fail = ({1'b0, free_cnt} < npg)
                    || (alloc_end > (BRK_BITS+1)'(1 << ADDR_BITS));
  assign rel_bytes  = {wn, {OFFSET_BITS{1'b0}}};
  assign brk_cmp    = {2'b00, addr_r} + {1'b0, rel_bytes};
  assign size_round = {1'b0, req.size} + (SIZE_BITS+1)'((1 << OFFSET_BITS) - 1);
  assign k_m1       = k - NPG_BITS'(1);
  assign scan_end   = scan_idx[FRAME_BITS] && !rd_pend;
  assign lookup_hit = rd_pend && frame_rd.mapped && (frame_rd.owner == pid_r)
                    && (frame_rd.vpage == addr_r[ADDR_BITS-1:OFFSET_BITS]);
  assign walk_ok    = (frame_rd.owner == pid_r) && frame_rd.mapped
                    && ({1'b0, frame_rd.vpage} == ({1'b0, vp0} + wn));

  assign frame_rd_addr = (state == S_WALK_RD) ? wf[FRAME_BITS-1:0]
                                              : scan_idx[FRAME_BITS-1:0];

  assign req.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.base_address = out_base;
  assign rsp.read_data    = out_rdata;

  always_ff @(posedge clk) begin
    fw.en <= 1'b0;
    br.we <= 1'b0;
    if (out_valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
    // shared sequential table scan, one read a cycle
    if (state == S_COUNT || state == S_ASSIGN || state == S_LOOKUP) begin
      if (!scan_idx[FRAME_BITS]) begin
        scan_idx <= scan_idx + 1'b1;
        rd_pend  <= 1'b1;
        rd_idx   <= scan_idx[FRAME_BITS-1:0];
      end else begin
        rd_pend <= 1'b0;
      end
    end
    unique case (state)
      S_CLEAR: begin
        br.we   <= 1'b1;
        br.addr <= clr_cnt;
        br.data <= '0;
        if (clr_cnt[ADDR_BITS-1:FRAME_BITS] == '0) begin
          fw.en   <= 1'b1;
          fw.addr <= clr_cnt[FRAME_BITS-1:0];
          fw.data <= '0;
        end
        if (clr_cnt == '1) begin
          state <= S_IDLE;
        end else begin
          clr_cnt <= clr_cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          cmd_r      <= cmd_t'(req.command);
          pid_r      <= req.pid;
          addr_r     <= req.address;
          wdata_r    <= req.write_data;
          npg        <= size_round[SIZE_BITS:OFFSET_BITS];
          res_status <= 1'b1;
          res_base   <= '0;
          res_rdata  <= '0;
          scan_idx   <= '0;
          rd_pend    <= 1'b0;
          free_cnt   <= '0;
          if (cmd_t'(req.command) == CMD_ALLOC) begin
            if (req.size == '0 || req.pid == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_COUNT;
            end
          end else begin
            state <= S_LOOKUP;
          end
        end
      end
      S_COUNT: begin
        if (rd_pend && frame_rd.owner == '0) begin
          free_cnt <= free_cnt + 1'b1;
        end
        if (scan_end) begin
          if (alloc_fail) begin
            state <= S_DONE;
          end else begin
            scan_idx <= '0;
            k        <= '0;
            vp0      <= bp_cur[ADDR_BITS-1:OFFSET_BITS];
            state    <= S_ASSIGN;
          end
        end
      end
      S_ASSIGN: begin
        // a frame is written once its successor is known
        if (k == npg || scan_end) begin
          state <= S_LINK_END;
        end else if (rd_pend && frame_rd.owner == '0) begin
          if (k != '0) begin
            fw.en         <= 1'b1;
            fw.addr       <= prev;
            fw.data.owner <= pid_r;
            fw.data.link  <= {1'b0, rd_idx};
            fw.data.vpage <= vp0 + k_m1[FRAME_BITS-1:0];
            fw.data.mapped <= 1'b1;
          end
          prev <= rd_idx;
          k    <= k + 1'b1;
        end
      end
      S_LINK_END: begin
        fw.en          <= 1'b1;
        fw.addr        <= prev;
        fw.data.owner  <= pid_r;
        fw.data.link   <= (FRAME_BITS+1)'(NUM_FRAMES);
        fw.data.vpage  <= vp0 + k_m1[FRAME_BITS-1:0];
        fw.data.mapped <= 1'b1;
        bp[pid_r]      <= alloc_end[BRK_BITS-1:0];
        res_base       <= bp_cur[ADDR_BITS-1:0];
        res_status     <= 1'b0;
        state          <= S_DONE;
      end
      S_LOOKUP: begin
        if (lookup_hit) begin
          if (cmd_r == CMD_FREE) begin
            wf    <= {1'b0, rd_idx};
            wn    <= '0;
            vp0   <= addr_r[ADDR_BITS-1:OFFSET_BITS];
            state <= S_WALK_RD;
          end else begin
            br.we   <= (cmd_r == CMD_WRITE);
            br.addr <= {rd_idx, addr_r[OFFSET_BITS-1:0]};
            br.data <= wdata_r;
            state   <= S_MEM_ISSUE;
          end
        end else if (scan_end) begin
          state <= S_DONE;
        end
      end
      S_WALK_RD: begin
        state <= S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (walk_ok) begin
          fw.en          <= 1'b1;
          fw.addr        <= wf[FRAME_BITS-1:0];
          fw.data.owner  <= '0;
          fw.data.link   <= frame_rd.link;
          fw.data.vpage  <= frame_rd.vpage;
          fw.data.mapped <= 1'b0;
          wn             <= wn + 1'b1;
          wf             <= frame_rd.link;
          if (frame_rd.link[FRAME_BITS] || wn == (FRAME_BITS+1)'(NUM_FRAMES - 1)) begin
            state <= S_BREAK;
          end else begin
            state <= S_WALK_RD;
          end
        end else begin
          state <= S_BREAK;
        end
      end
      S_BREAK: begin
        if ({1'b0, bp_cur} == brk_cmp) begin
          bp[pid_r] <= bp_cur - rel_bytes;
        end
        res_status <= 1'b0;
        state      <= S_DONE;
      end
      S_MEM_ISSUE: begin
        state <= S_MEM_WAIT;
      end
      S_MEM_WAIT: begin
        if (cmd_r == CMD_READ) begin
          res_rdata <= byte_rd;
        end
        res_status <= 1'b0;
        state      <= S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid  <= 1'b1;
          out_status <= res_status;
          out_base   <= res_base;
          out_rdata  <= res_rdata;
          state      <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (cfg.valid) begin
      for (int p = 0; p < MAX_PROCS; p++) begin
        bp[p] <= cfg.initial_break;
      end
    end
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      fw.en     <= 1'b0;
      br.we     <= 1'b0;
      rd_pend   <= 1'b0;
      for (int p = 0; p < MAX_PROCS; p++) begin
        bp[p] <= BRK_RESET;
      end
    end
  end

endmodule
`default_nettype wire

### src/paged_memory_manager_top.sv
// paged memory manager: per-process frame allocator with byte access
//
// channels: req carries one command (allocate, free, read byte, write byte)
// with pid, size, address and write_data; rsp returns one result per command
// with status, base_address and read_data; cfg writes the initial break,
// which also reloads the break of every process
// an item is a transfer on valid and ready; cfg is always ready
//
// command steps; the frame table has a single read port, scanned one entry a cycle:
//   allocate: a free count scan, then an assignment scan
//   free: a lookup scan, then a walk that releases each frame in turn
//   read / write: a lookup scan, then the byte access
// one command is in flight at a time; req is ready again once the result sits
// in the output register, so a stalled rsp holds only that one result
// reset: a pass over all 2^20 addresses zeroes the byte store and the frame
// table; req stays not ready until it ends, cfg writes are taken throughout
// every break pointer returns to 1024 at reset
`default_nettype none
module paged_memory_manager_top import pmm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pmm_req_if.sink   req,
  pmm_rsp_if.source rsp,
  pmm_cfg_if.sink   cfg
);

  // frame table: owner, link, virtual page and mapped flag per frame
  frame_wr_t             fw;
  logic [FRAME_BITS-1:0] frame_rd_addr;
  frame_entry_t          frame_rd;

  // physical byte store
  byte_req_t             br;
  logic [BYTE_BITS-1:0]  byte_rd;

  // command sequencer, break pointers and result register
  pmm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .cfg           (cfg),
    .fw            (fw),
    .frame_rd_addr (frame_rd_addr),
    .frame_rd      (frame_rd),
    .br            (br),
    .byte_rd       (byte_rd)
  );

  pmm_frame_mem u_frame_mem (
    .clk     (clk),
    .wr      (fw),
    .rd_addr (frame_rd_addr),
    .rd_data (frame_rd)
  );

  pmm_byte_mem u_byte_mem (
    .clk     (clk),
    .req     (br),
    .rd_data (byte_rd)
  );

endmodule
`default_nettype wire
